// File: hw/rtl/ir_emitter_drive_calibrator_macros.svh
// Assertion helpers for the top-level calibrator source.
`ifndef IR_EMITTER_DRIVE_CALIBRATOR_MACROS_SVH
`define IR_EMITTER_DRIVE_CALIBRATOR_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define IEDC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IEDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/iedc_pkg.sv
`timescale 1ns / 1ps

package iedc_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int LEVEL_W     = 9;
   localparam int DUTY_W      = 16;
   localparam int TICK_W      = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 56;
   localparam int PROD_W      = SAMPLE_W + LEVEL_W;

   localparam int unsigned LEVEL_SCALE = 330;

   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = 1;
   localparam int QCNT_W  = 2;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_LEFT  = 2'd1;
   localparam logic [1:0] PH_RIGHT = 2'd2;

   localparam logic [2:0] FL_PASS = 3'b001;
   localparam logic [2:0] FL_ERR  = 3'b010;
   localparam logic [2:0] FL_CONF = 3'b100;

   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_DUTY_MIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_DUTY_MAX   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_DUTY_MIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_DUTY_MAX  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_DIVIDER    = 3'd5;

   typedef struct packed {
      logic [LEVEL_W-1:0] level_threshold;
      logic [DUTY_W-1:0]  left_duty_min;
      logic [DUTY_W-1:0]  left_duty_max;
      logic [DUTY_W-1:0]  right_duty_min;
      logic [DUTY_W-1:0]  right_duty_max;
      logic [TICK_W-1:0]  tick_divider;
   } cfg_type;

   typedef struct packed {
      logic               is_start;
      logic [LEVEL_W-1:0] left_level;
      logic [LEVEL_W-1:0] right_level;
   } item_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } qstat_type;

   typedef struct packed {
      logic              wrap;
      logic [DUTY_W-1:0] duty;
   } step_type;

   function automatic step_type step_duty(input logic [DUTY_W-1:0] duty,
                                          input logic [DUTY_W-1:0] lo,
                                          input logic [DUTY_W-1:0] hi);
      logic [DUTY_W:0] nxt;
      step_type        r;
      nxt = {1'b0, duty} + {{DUTY_W{1'b0}}, 1'b1};
      if (nxt > {1'b0, hi}) begin
         r.wrap = 1'b1;
         r.duty = lo;
      end else begin
         r.wrap = 1'b0;
         r.duty = nxt[DUTY_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/iedc_front.sv
`timescale 1ns / 1ps

module iedc_front (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [iedc_pkg::REQ_DATA_W-1:0]    req_tdata,   // left_sample, right_sample
   input  logic                               req_tuser,   // req_type
   input  iedc_pkg::qstat_type                q_stat,
   output logic                               q_write,
   output iedc_pkg::item_type                 q_item
);
   import iedc_pkg::*;

   logic [PROD_W-1:0] left_prod;
   logic [PROD_W-1:0] right_prod;

   // scale raw samples: (sample * 330) >> 12
   assign left_prod  = PROD_W'(req_tdata[SAMPLE_W-1:0]) * PROD_W'(LEVEL_SCALE);
   assign right_prod = PROD_W'(req_tdata[2*SAMPLE_W-1:SAMPLE_W]) * PROD_W'(LEVEL_SCALE);

   assign req_tready = !q_stat.full;
   assign q_write    = req_tvalid && !q_stat.full;

   assign q_item.is_start    = req_tuser;
   assign q_item.left_level  = left_prod[PROD_W-1:SAMPLE_W];
   assign q_item.right_level = right_prod[PROD_W-1:SAMPLE_W];

endmodule

// File: hw/rtl/iedc_queue.sv
`timescale 1ns / 1ps

module iedc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  iedc_pkg::item_type  wr_item,
   input  logic                rd_en,
   output iedc_pkg::item_type  rd_item,
   output iedc_pkg::qstat_type stat
);
   import iedc_pkg::*;

   item_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   assign rd_item    = mem_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.full  = (count_ff == QCNT_W'(QDEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

// File: hw/rtl/iedc_back.sv
`timescale 1ns / 1ps

module iedc_back (
   input  logic                            clock,
   input  logic                            reset,
   input  iedc_pkg::cfg_type               cfg,
   input  iedc_pkg::qstat_type             q_stat,
   input  iedc_pkg::item_type              q_item,
   output logic                            q_read,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [iedc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                      phase
);
   import iedc_pkg::*;

   logic [1:0]             phase_ff, phase_in;
   logic [DUTY_W-1:0]      ldut_ff, ldut_in;
   logic [DUTY_W-1:0]      rdut_ff, rdut_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic                   sreq_ff, sreq_in;
   logic                   sok_ff, sok_in;
   logic [2:0]             lfl_ff, lfl_in;
   logic [2:0]             rfl_ff, rfl_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                   done, pass, busy, low_l, low_r;
   step_type               st;

   assign q_read = !q_stat.empty && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      phase_in = phase_ff;
      ldut_in  = ldut_ff;
      rdut_in  = rdut_ff;
      tick_in  = tick_ff;
      sreq_in  = sreq_ff;
      sok_in   = sok_ff;
      lfl_in   = lfl_ff;
      rfl_in   = rfl_ff;
      done     = 1'b0;
      pass     = 1'b0;
      low_l    = q_item.left_level < cfg.level_threshold;
      low_r    = q_item.right_level < cfg.level_threshold;
      st       = '0;
      if (q_item.is_start) begin
         ldut_in  = cfg.left_duty_min;
         rdut_in  = cfg.right_duty_min;
         tick_in  = '0;
         sreq_in  = 1'b0;
         sok_in   = 1'b0;
         lfl_in   = '0;
         rfl_in   = '0;
         phase_in = PH_LEFT;
      end else if (phase_ff == PH_LEFT || phase_ff == PH_RIGHT) begin
         tick_in = tick_ff + TICK_W'(1);
         if (tick_in >= cfg.tick_divider) begin
            tick_in = '0;
            if (phase_ff == PH_LEFT) begin
               if ((lfl_in & (FL_PASS | FL_ERR)) == '0) begin
                  if (low_l) begin
                     st      = step_duty(ldut_in, cfg.left_duty_min, cfg.left_duty_max);
                     ldut_in = st.duty;
                     if (st.wrap) begin
                        lfl_in  = FL_ERR;
                        sreq_in = 1'b1;
                        sok_in  = 1'b0;
                     end
                  end else begin
                     lfl_in  = FL_PASS;
                     sreq_in = 1'b0;
                     sok_in  = 1'b0;
                  end
               end
               if (sreq_in) begin
                  if (low_l) begin
                     st      = step_duty(rdut_in, cfg.right_duty_min, cfg.right_duty_max);
                     rdut_in = st.duty;
                     if (st.wrap) begin
                        lfl_in  = FL_CONF;
                        sreq_in = 1'b0;
                        sok_in  = 1'b0;
                     end
                  end else begin
                     lfl_in  = FL_PASS;
                     sreq_in = 1'b1;
                     sok_in  = 1'b1;
                  end
               end
               if ((lfl_in & (FL_PASS | FL_CONF)) != '0) begin
                  phase_in = PH_RIGHT;
               end
            end else if (sok_in) begin
               if (low_r) begin
                  st      = step_duty(ldut_in, cfg.left_duty_min, cfg.left_duty_max);
                  ldut_in = st.duty;
                  if (st.wrap) begin
                     rfl_in = (rfl_in & FL_ERR) | FL_CONF;
                  end
               end else begin
                  rfl_in = (rfl_in & FL_ERR) | FL_PASS;
               end
            end else begin
               if ((rfl_in & (FL_PASS | FL_ERR)) == '0) begin
                  if (low_r) begin
                     st      = step_duty(rdut_in, cfg.right_duty_min, cfg.right_duty_max);
                     rdut_in = st.duty;
                     if (st.wrap) begin
                        if ((lfl_in & FL_CONF) != '0) begin
                           rfl_in  = FL_ERR;
                           sreq_in = 1'b1;
                           sok_in  = 1'b0;
                        end else begin
                           rfl_in = FL_CONF;
                        end
                     end
                  end else begin
                     rfl_in  = FL_PASS;
                     sreq_in = 1'b0;
                     sok_in  = 1'b0;
                  end
               end
               if (sreq_in) begin
                  if (low_r) begin
                     st      = step_duty(ldut_in, cfg.left_duty_min, cfg.left_duty_max);
                     ldut_in = st.duty;
                     if (st.wrap) begin
                        rfl_in  = FL_CONF;
                        sreq_in = 1'b1;
                        sok_in  = 1'b0;
                     end
                  end else begin
                     rfl_in  = FL_PASS;
                     sreq_in = 1'b1;
                     sok_in  = 1'b1;
                  end
               end
            end
            if (phase_in == PH_RIGHT && (rfl_in & (FL_PASS | FL_CONF)) != '0) begin
               done     = 1'b1;
               pass     = ((lfl_in & (FL_PASS | FL_CONF)) == FL_PASS) &&
                          ((rfl_in & (FL_PASS | FL_CONF)) == FL_PASS);
               lfl_in   = '0;
               rfl_in   = '0;
               sreq_in  = 1'b0;
               sok_in   = 1'b0;
               phase_in = PH_IDLE;
            end
         end
      end
      busy = (phase_in == PH_LEFT || phase_in == PH_RIGHT);
   end

   assign rsp_data_in = {3'b000, pass, done, busy, q_item.right_level, q_item.left_level,
                         rdut_in, ldut_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         ldut_ff      <= '0;
         rdut_ff      <= '0;
         tick_ff      <= '0;
         sreq_ff      <= 1'b0;
         sok_ff       <= 1'b0;
         lfl_ff       <= '0;
         rfl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_read) begin
            phase_ff <= phase_in;
            ldut_ff  <= ldut_in;
            rdut_ff  <= rdut_in;
            tick_ff  <= tick_in;
            sreq_ff  <= sreq_in;
            sok_ff   <= sok_in;
            lfl_ff   <= lfl_in;
            rfl_ff   <= rfl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_read) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign phase      = phase_ff;

endmodule

// File: hw/rtl/ir_emitter_drive_calibrator.sv
// Path: an accepted req word is written into the queue, then popped into the registered rsp output once that is free.
// Throughput: one word per cycle while rsp_tready is not held low; the front scaling is combinational
// and the back state update is registered, the two decoupled by a two-entry queue.
// Reset: synchronous, active high; phase idle, duties and flags zero,
// configuration registers back to their defaults, queue and output empty.
`timescale 1ns / 1ps
`include "ir_emitter_drive_calibrator_macros.svh"

module ir_emitter_drive_calibrator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [iedc_pkg::REQ_DATA_W-1:0]    req_tdata,   // left_sample, right_sample
   input  logic                               req_tuser,   // req_type
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // left_duty, right_duty, left_level, right_level, busy_res, done_res, passed
   output logic [iedc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [iedc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [iedc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import iedc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   qstat_type  q_stat;
   item_type   wr_item, rd_item;
   logic       q_write, q_read;
   logic [1:0] phase;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LEVEL_THRESHOLD: cfg_in.level_threshold = csr_wdata[LEVEL_W-1:0];
            CSR_LEFT_DUTY_MIN:   cfg_in.left_duty_min   = csr_wdata[DUTY_W-1:0];
            CSR_LEFT_DUTY_MAX:   cfg_in.left_duty_max   = csr_wdata[DUTY_W-1:0];
            CSR_RIGHT_DUTY_MIN:  cfg_in.right_duty_min  = csr_wdata[DUTY_W-1:0];
            CSR_RIGHT_DUTY_MAX:  cfg_in.right_duty_max  = csr_wdata[DUTY_W-1:0];
            CSR_TICK_DIVIDER:    cfg_in.tick_divider    = csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_threshold <= LEVEL_W'(100);
         cfg_ff.left_duty_min   <= '0;
         cfg_ff.left_duty_max   <= DUTY_W'(1000);
         cfg_ff.right_duty_min  <= '0;
         cfg_ff.right_duty_max  <= DUTY_W'(1000);
         cfg_ff.tick_divider    <= TICK_W'(20);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   iedc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .q_write    (q_write),
      .q_item     (wr_item)
   );

   iedc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_write),
      .wr_item (wr_item),
      .rd_en   (q_read),
      .rd_item (rd_item),
      .stat    (q_stat)
   );

   iedc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_stat     (q_stat),
      .q_item     (rd_item),
      .q_read     (q_read),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .phase      (phase)
   );

   `IEDC_ASSERT_ALWAYS(a_no_overflow, !(q_write && q_stat.full), "queue written while full")
   `IEDC_ASSERT_NEXT(a_write_lands, q_write, !q_stat.empty, "accepted word missing from queue")
   `IEDC_ASSERT_ALWAYS(a_done_idle, !(rsp_tvalid && rsp_tdata[51] && rsp_tdata[50]), "done while busy")
   `IEDC_ASSERT_NEXT(a_pop_fills_out, q_read, rsp_tvalid, "popped word not presented")
   `IEDC_ASSERT_ALWAYS(a_phase_legal, phase != 2'd3, "unused phase code reached")

endmodule

// File: dv/tb_ir_emitter_drive_calibrator.sv
`timescale 1ns / 1ps

module tb_ir_emitter_drive_calibrator;
   import iedc_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 80;

   typedef struct {
      logic [DUTY_W-1:0]  left_duty;
      logic [DUTY_W-1:0]  right_duty;
      logic [LEVEL_W-1:0] left_level;
      logic [LEVEL_W-1:0] right_level;
      logic               busy;
      logic               done;
      logic               passed;
   } drive_report_type;

   class calib_scoreboard;
      cfg_type           cfg;
      logic [1:0]        phase;
      logic [DUTY_W-1:0] left_duty;
      logic [DUTY_W-1:0] right_duty;
      logic [TICK_W-1:0] tick_count;
      logic              swap_req;
      logic              swap_good;
      logic [2:0]        left_fl;
      logic [2:0]        right_fl;
      drive_report_type  report_q[$];
      int                mismatches;
      int                live_items;
      int                n_checked;

      function new();
         cfg.level_threshold = 9'd100;
         cfg.left_duty_min   = 16'd0;
         cfg.left_duty_max   = 16'd1000;
         cfg.right_duty_min  = 16'd0;
         cfg.right_duty_max  = 16'd1000;
         cfg.tick_divider    = 8'd20;
         phase      = PH_IDLE;
         left_duty  = '0;
         right_duty = '0;
         tick_count = '0;
         swap_req   = 1'b0;
         swap_good  = 1'b0;
         left_fl    = '0;
         right_fl   = '0;
         mismatches = 0;
         live_items = 0;
         n_checked  = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_LEVEL_THRESHOLD: cfg.level_threshold = val[LEVEL_W-1:0];
            CSR_LEFT_DUTY_MIN:   cfg.left_duty_min   = val;
            CSR_LEFT_DUTY_MAX:   cfg.left_duty_max   = val;
            CSR_RIGHT_DUTY_MIN:  cfg.right_duty_min  = val;
            CSR_RIGHT_DUTY_MAX:  cfg.right_duty_max  = val;
            CSR_TICK_DIVIDER:    cfg.tick_divider    = val[TICK_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [LEVEL_W-1:0] level_of(logic [SAMPLE_W-1:0] s);
         logic [20:0] prod;
         prod = {9'd0, s} * 21'd330;
         return prod[20:12];
      endfunction

      // advance a duty by one; wrap to min past max, compared at 17 bits
      function bit bump_left();
         logic [DUTY_W:0] nxt;
         nxt = {1'b0, left_duty} + 17'd1;
         if (nxt > {1'b0, cfg.left_duty_max}) begin
            left_duty = cfg.left_duty_min;
            return 1'b1;
         end
         left_duty = nxt[DUTY_W-1:0];
         return 1'b0;
      endfunction

      function bit bump_right();
         logic [DUTY_W:0] nxt;
         nxt = {1'b0, right_duty} + 17'd1;
         if (nxt > {1'b0, cfg.right_duty_max}) begin
            right_duty = cfg.right_duty_min;
            return 1'b1;
         end
         right_duty = nxt[DUTY_W-1:0];
         return 1'b0;
      endfunction

      function void eval_left(bit low);
         if ((left_fl & (FL_PASS | FL_ERR)) == 3'b000) begin
            if (low) begin
               if (bump_left()) begin
                  left_fl   = FL_ERR;
                  swap_req  = 1'b1;
                  swap_good = 1'b0;
               end
            end else begin
               left_fl   = FL_PASS;
               swap_req  = 1'b0;
               swap_good = 1'b0;
            end
         end
         if (swap_req) begin
            if (low) begin
               if (bump_right()) begin
                  left_fl   = FL_CONF;
                  swap_req  = 1'b0;
                  swap_good = 1'b0;
               end
            end else begin
               left_fl   = FL_PASS;
               swap_req  = 1'b1;
               swap_good = 1'b1;
            end
         end
         if ((left_fl & (FL_PASS | FL_CONF)) != 3'b000) phase = PH_RIGHT;
      endfunction

      function void eval_right(bit low);
         if (swap_good) begin
            if (low) begin
               if (bump_left()) right_fl = (right_fl & FL_ERR) | FL_CONF;
            end else begin
               right_fl = (right_fl & FL_ERR) | FL_PASS;
            end
            return;
         end
         if ((right_fl & (FL_PASS | FL_ERR)) == 3'b000) begin
            if (low) begin
               if (bump_right()) begin
                  if ((left_fl & FL_CONF) != 3'b000) begin
                     right_fl  = FL_ERR;
                     swap_req  = 1'b1;
                     swap_good = 1'b0;
                  end else begin
                     right_fl = FL_CONF;
                  end
               end
            end else begin
               right_fl  = FL_PASS;
               swap_req  = 1'b0;
               swap_good = 1'b0;
            end
         end
         if (swap_req) begin
            if (low) begin
               if (bump_left()) begin
                  right_fl  = FL_CONF;
                  swap_req  = 1'b1;
                  swap_good = 1'b0;
               end
            end else begin
               right_fl  = FL_PASS;
               swap_req  = 1'b1;
               swap_good = 1'b1;
            end
         end
      endfunction

      function void note_input(logic is_start, logic [SAMPLE_W-1:0] ls,
                               logic [SAMPLE_W-1:0] rs);
         drive_report_type r;
         r.left_level  = level_of(ls);
         r.right_level = level_of(rs);
         r.done        = 1'b0;
         r.passed      = 1'b0;
         if (is_start) begin
            live_items++;
            left_duty  = cfg.left_duty_min;
            right_duty = cfg.right_duty_min;
            tick_count = '0;
            swap_req   = 1'b0;
            swap_good  = 1'b0;
            left_fl    = '0;
            right_fl   = '0;
            phase      = PH_LEFT;
         end else if (phase == PH_LEFT || phase == PH_RIGHT) begin
            live_items++;
            tick_count++;
            if (tick_count >= cfg.tick_divider) begin
               tick_count = '0;
               if (phase == PH_LEFT) eval_left(r.left_level < cfg.level_threshold);
               else eval_right(r.right_level < cfg.level_threshold);
               if (phase == PH_RIGHT && (right_fl & (FL_PASS | FL_CONF)) != 3'b000) begin
                  r.done   = 1'b1;
                  r.passed = ((left_fl & (FL_PASS | FL_CONF)) == FL_PASS) &&
                             ((right_fl & (FL_PASS | FL_CONF)) == FL_PASS);
                  left_fl   = '0;
                  right_fl  = '0;
                  swap_req  = 1'b0;
                  swap_good = 1'b0;
                  phase     = PH_IDLE;
               end
            end
         end
         r.left_duty  = left_duty;
         r.right_duty = right_duty;
         r.busy       = (phase == PH_LEFT || phase == PH_RIGHT);
         report_q.push_back(r);
      endfunction

      function void cmp(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch %s: expected %0d got %0d", name, want, got);
         end
      endfunction

      function void check(logic [RSP_DATA_W-1:0] d);
         drive_report_type e;
         n_checked++;
         if (report_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp word %h", d);
            return;
         end
         e = report_q.pop_front();
         cmp("left_duty",   32'(e.left_duty),   32'(d[15:0]));
         cmp("right_duty",  32'(e.right_duty),  32'(d[31:16]));
         cmp("left_level",  32'(e.left_level),  32'(d[40:32]));
         cmp("right_level", 32'(e.right_level), 32'(d[49:41]));
         cmp("busy_res",    32'(e.busy),        32'(d[50]));
         cmp("done_res",    32'(e.done),        32'(d[51]));
         cmp("passed",      32'(e.passed),      32'(d[52]));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   bit              hold_go = 1'b0;
   int              n_sent = 0;
   cfg_type         cur_cfg;
   calib_scoreboard sb;

   ir_emitter_drive_calibrator DUT (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_input(req_tuser, req_tdata[11:0], req_tdata[23:12]);
         if (rsp_tvalid && rsp_tready) sb.check(rsp_tdata);
      end
   end

   initial begin
      int hold_n;
      hold_n = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            hold_n  = HOLD_CYCLES;
         end
         if (hold_n > 0) begin
            hold_n--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) quiet = 0;
         else quiet++;
      end
      $display("ir_emitter_drive_calibrator verification failed");
      $finish;
   end

   task automatic send_word(input logic is_start, input logic [SAMPLE_W-1:0] ls,
                            input logic [SAMPLE_W-1:0] rs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= is_start;
      req_tdata  <= {rs, ls};
      do @(posedge clock); while (!req_tready);
      n_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.n_checked < n_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_cfg(input cfg_type c);
      logic [CSR_IDX_W-1:0]  idx[6];
      logic [CSR_DATA_W-1:0] val[6];
      idx = '{CSR_LEVEL_THRESHOLD, CSR_LEFT_DUTY_MIN, CSR_LEFT_DUTY_MAX,
              CSR_RIGHT_DUTY_MIN, CSR_RIGHT_DUTY_MAX, CSR_TICK_DIVIDER};
      val = '{{7'd0, c.level_threshold}, c.left_duty_min, c.left_duty_max,
              c.right_duty_min, c.right_duty_max, {8'd0, c.tick_divider}};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         sb.set_reg(idx[i], val[i]);
      end
      csr_we  <= 1'b0;
      cur_cfg = c;
   endtask

   function automatic cfg_type rand_cfg();
      cfg_type c;
      int      span;
      c.level_threshold = LEVEL_W'($urandom_range(330));
      span = $urandom_range(6);
      c.left_duty_min = DUTY_W'($urandom_range(65535 - span));
      c.left_duty_max = DUTY_W'(c.left_duty_min + span);
      if ($urandom_range(4) == 0)
         {c.left_duty_min, c.left_duty_max} = {c.left_duty_max, c.left_duty_min};
      span = $urandom_range(6);
      c.right_duty_min = DUTY_W'($urandom_range(65535 - span));
      c.right_duty_max = DUTY_W'(c.right_duty_min + span);
      if ($urandom_range(4) == 0)
         {c.right_duty_min, c.right_duty_max} = {c.right_duty_max, c.right_duty_min};
      c.tick_divider = ($urandom_range(9) == 0) ? TICK_W'($urandom_range(8, 1))
                                                : TICK_W'($urandom_range(3, 1));
      return c;
   endfunction

   // bias a sample above or below the current pass threshold
   function automatic logic [SAMPLE_W-1:0] pick_sample(input int pass_pct);
      int floor_s;
      floor_s = (int'(cur_cfg.level_threshold) * 4096 + 329) / 330;
      if (floor_s == 0 || floor_s > 4095 || $urandom_range(9) == 0)
         return SAMPLE_W'($urandom_range(4095));
      if ($urandom_range(99) < pass_pct) return SAMPLE_W'($urandom_range(4095, floor_s));
      return SAMPLE_W'($urandom_range(floor_s - 1, 0));
   endfunction

   task automatic run_traffic(input int target);
      int base;
      int ticks;
      int pass_pct;
      base = sb.live_items;
      while (sb.live_items - base < target) begin
         pass_pct = $urandom_range(100);
         if ($urandom_range(99) < 85)
            send_word(1'b1, SAMPLE_W'($urandom_range(4095)), SAMPLE_W'($urandom_range(4095)));
         ticks = int'(cur_cfg.tick_divider) * $urandom_range(30, 1);
         for (int i = 0; i < ticks && sb.live_items - base < target; i++) begin
            if ($urandom_range(99) < 2)
               send_word(1'b1, SAMPLE_W'($urandom_range(4095)),
                         SAMPLE_W'($urandom_range(4095)));
            else if ($urandom_range(99) < 3)
               send_word(1'b0, SAMPLE_W'($urandom_range(4095)),
                         SAMPLE_W'($urandom_range(4095)));
            else
               send_word(1'b0, pick_sample(pass_pct), pick_sample(pass_pct));
         end
      end
   endtask

   task automatic run_phase(input cfg_type c, input int send_pct, input int recv_pct,
                            input int target, input bit hold);
      write_cfg(c);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (hold) hold_go = 1'b1;
      run_traffic(target);
      drain();
   endtask

   initial begin
      cfg_type c;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      sb         = new();
      cur_cfg    = sb.cfg;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // idle ticks, then restart while running, at reset settings
      send_word(1'b0, 12'd0, 12'd0);
      send_word(1'b0, 12'hFFF, 12'hFFF);
      send_word(1'b1, 12'hFFF, 12'd0);
      send_word(1'b0, 12'd0, 12'hFFF);
      send_word(1'b0, 12'hFFF, 12'd0);
      send_word(1'b1, 12'd0, 12'd0);
      drain();

      // always low: wrap at the top of the duty range, confirmed errors, fail
      c.level_threshold = 9'd330;
      c.left_duty_min   = 16'd65534;
      c.left_duty_max   = 16'd65535;
      c.right_duty_min  = 16'd0;
      c.right_duty_max  = 16'd0;
      c.tick_divider    = 8'd1;
      write_cfg(c);
      send_word(1'b1, 12'd0, 12'd0);
      send_word(1'b0, 12'd0, 12'd0);
      send_word(1'b0, 12'hFFF, 12'hFFF);
      send_word(1'b0, 12'd0, 12'hFFF);
      send_word(1'b0, 12'hFFF, 12'd0);
      send_word(1'b0, 12'd0, 12'd0);
      send_word(1'b0, 12'hFFF, 12'hFFF);
      drain();

      // threshold zero: immediate pass
      c.level_threshold = 9'd0;
      c.left_duty_min   = 16'd10;
      c.left_duty_max   = 16'd3;
      c.right_duty_min  = 16'd65535;
      c.right_duty_max  = 16'd0;
      write_cfg(c);
      send_word(1'b1, 12'd0, 12'd0);
      send_word(1'b0, 12'd0, 12'd0);
      send_word(1'b0, 12'd0, 12'd0);
      send_word(1'b0, 12'hFFF, 12'd0);
      drain();

      // duty above max wraps at once, swap succeeds, right phase on swapped drive
      c.level_threshold = 9'd200;
      c.left_duty_min   = 16'd9;
      c.left_duty_max   = 16'd3;
      c.right_duty_min  = 16'd0;
      c.right_duty_max  = 16'd5;
      c.tick_divider    = 8'd2;
      write_cfg(c);
      send_word(1'b1, 12'd0, 12'd0);
      send_word(1'b0, 12'd0, 12'd0);
      send_word(1'b0, 12'd0, 12'd0);
      send_word(1'b0, 12'hFFF, 12'd0);
      send_word(1'b0, 12'hFFF, 12'd0);
      send_word(1'b0, 12'd0, 12'hFFF);
      send_word(1'b0, 12'd0, 12'hFFF);
      drain();

      run_phase(rand_cfg(), 0, 0, 45, 1'b1);
      run_phase(rand_cfg(), 84, 0, 45, 1'b0);
      run_phase(rand_cfg(), 0, 84, 45, 1'b0);
      run_phase(rand_cfg(), 11, 11, 45, 1'b0);

      c = rand_cfg();
      c.level_threshold = 9'd0;
      c.tick_divider    = 8'd255;
      run_phase(c, 0, 0, 260, 1'b0);

      c = rand_cfg();
      c.level_threshold = 9'd330;
      c.left_duty_min   = 16'd65535;
      c.left_duty_max   = 16'd65535;
      c.right_duty_min  = 16'd65530;
      c.right_duty_max  = 16'd65535;
      c.tick_divider    = 8'd1;
      run_phase(c, 84, 0, 45, 1'b0);

      run_phase(rand_cfg(), 0, 84, 45, 1'b0);
      run_phase(rand_cfg(), 11, 11, 45, 1'b0);
      run_phase(rand_cfg(), 0, 0, 45, 1'b0);

      if (sb.mismatches == 0 && sb.report_q.size() == 0)
         $display("ir_emitter_drive_calibrator verification clean");
      else
         $display("ir_emitter_drive_calibrator verification failed");
      $finish;
   end

endmodule

// File: ir_emitter_drive_calibrator.f
+incdir+hw/rtl
hw/rtl/iedc_pkg.sv
hw/rtl/iedc_front.sv
hw/rtl/iedc_queue.sv
hw/rtl/iedc_back.sv
hw/rtl/ir_emitter_drive_calibrator.sv
dv/tb_ir_emitter_drive_calibrator.sv
